### rtl/core/sbta_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and sizing function for the signed binary to
// base-3 ASCII converter. No dependencies.
package sbta_pkg;

  // ASCII codes, six bits wide as on the output port
  localparam logic [5:0] CH_ZERO  = 6'd48;
  localparam logic [5:0] CH_MINUS = 6'd45;

  typedef logic [1:0] digit_t;

  // Commands from the sequencer to the digit accumulator
  typedef struct packed {
    logic load;   // clear digits, mark the units position significant
    logic step;   // double and add the incoming binary bit
    logic shift;  // move every digit one position towards the top
  } conv_ctrl_t;

  // Base-3 digits needed for the largest magnitude, 2^(width-1)
  function automatic int num_digits(input int width);
    logic [65:0] lim;
    logic [65:0] pw;
    int          d;
    lim = 66'd1 << (width - 1);
    pw  = 66'd1;
    d   = 0;
    for (int i = 0; i < 64; i++) begin
      if (pw <= lim) begin
        pw = pw + (pw << 1);
        d  = d + 1;
      end
    end
    return d;
  endfunction

endpackage

### rtl/core/signed_binary_to_ternary_ascii.sv
`timescale 1ns / 1ps
// Top level of the signed binary to base-3 ASCII converter: sequencer, sign
// handling and output register. Uses sbta_pkg and sbta_conv.
//
// Usage: a transfer on the value channel (value_valid high, value_stall low)
// delivers one two's complement number; the low VALUE_WIDTH bits are used.
// The block answers with a run of transfers on the character channel: a
// minus sign first for a negative number, then the base-3 digits of the
// magnitude, most significant first, with no leading zeros ('0' for zero).
// last marks the final character of each number.
// Sequence: after a value transfer the accumulator takes VALUE_WIDTH
// steps, one binary bit per cycle from the top down; a minus sign, if any,
// is then loaded; then the digit register is scanned from the top over
// DIGITS positions (40 at width 64), skipping leading zeros and emitting
// one character per cycle while the character channel does not stall.
// value_stall stays high until the last character is in the output
// register.
// Reset clears the sequencer and the output valid flag. A stall on the
// character channel holds the output register and freezes the scan once
// a character is due to be loaded; leading zeros are still skipped.
module signed_binary_to_ternary_ascii #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] value,
  input  logic        value_valid,
  output logic        value_stall,
  output logic [5:0]  character,
  output logic        last,
  output logic        character_valid,
  input  logic        character_stall
);

  localparam int DIGITS = sbta_pkg::num_digits(VALUE_WIDTH);
  localparam int BCW    = $clog2(VALUE_WIDTH);
  localparam int PCW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [VALUE_WIDTH-1:0]  mag, mag_next;
  logic                    neg, neg_next;
  logic [BCW-1:0]          bit_cnt, bit_cnt_next;
  logic [PCW-1:0]          pos, pos_next;
  logic                    started, started_next;
  logic [5:0]              char_next;
  logic                    last_next;
  logic                    out_load;
  logic                    out_free;
  logic                    take;
  logic                    emit_now;
  logic [VALUE_WIDTH-1:0]  raw;
  sbta_pkg::conv_ctrl_t    ctrl;
  sbta_pkg::digit_t        top_digit;
  logic                    top_sig;

  assign raw         = value[VALUE_WIDTH-1:0];
  assign value_stall = (state != ST_IDLE);
  assign take        = value_valid && (state == ST_IDLE);
  // The output register can take a new character when empty or draining
  assign out_free    = !character_valid || !character_stall;
  // Once the first significant digit is reached, emit every digit below it
  assign emit_now    = started || top_sig;

  sbta_conv #(
    .DIGITS (DIGITS)
  ) u_conv (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (mag[VALUE_WIDTH-1]),
    .top_digit (top_digit),
    .top_sig   (top_sig)
  );

  always_comb begin
    state_next   = state;
    mag_next     = mag;
    neg_next     = neg;
    bit_cnt_next = bit_cnt;
    pos_next     = pos;
    started_next = started;
    char_next    = character;
    last_next    = last;
    out_load     = 1'b0;
    ctrl         = '0;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          // Magnitude as an unsigned number: the most negative value fits
          neg_next     = raw[VALUE_WIDTH-1];
          mag_next     = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
          bit_cnt_next = BCW'(VALUE_WIDTH - 1);
          ctrl.load    = 1'b1;
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.step = 1'b1;
        mag_next  = mag << 1;
        bit_cnt_next = bit_cnt - 1'b1;
        if (bit_cnt == '0) begin
          pos_next     = PCW'(DIGITS - 1);
          started_next = 1'b0;
          state_next   = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          char_next  = sbta_pkg::CH_MINUS;
          last_next  = 1'b0;
          out_load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_now || out_free) begin
          ctrl.shift = 1'b1;
          pos_next   = pos - 1'b1;
          if (emit_now) begin
            char_next    = sbta_pkg::CH_ZERO + {4'b0000, top_digit};
            last_next    = (pos == '0);
            out_load     = 1'b1;
            started_next = 1'b1;
          end
          if (pos == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      character_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        character_valid <= 1'b1;
      end else if (!character_stall) begin
        character_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers: no reset needed
  always_ff @(posedge clk) begin
    mag     <= mag_next;
    neg     <= neg_next;
    bit_cnt <= bit_cnt_next;
    pos     <= pos_next;
    started <= started_next;
    if (out_load) begin
      character <= char_next;
      last      <= last_next;
    end
  end

endmodule

### rtl/core/sbta_conv.sv
`timescale 1ns / 1ps
// Base-3 digit accumulator: doubles a register of ternary digits and adds one
// binary bit per step, then shifts digits out from the top. Uses sbta_pkg.
module sbta_conv #(
  parameter int DIGITS = 40
) (
  input  logic                  clk,
  input  sbta_pkg::conv_ctrl_t  ctrl,
  input  logic                  bit_in,
  output sbta_pkg::digit_t      top_digit,
  output logic                  top_sig
);

  logic [DIGITS-1:0][1:0] digits;
  logic [DIGITS-1:0][1:0] digits_dbl;
  logic [DIGITS-1:0]      occ;
  logic [DIGITS-1:0]      occ_dbl;
  logic [DIGITS-1:0]      gen;
  logic [DIGITS-1:0]      prop;
  logic [DIGITS-1:0]      sum;
  logic [DIGITS-1:0]      carry;

  // Carry into digit i+1 is set when 2*d+c >= 3: generate on a two,
  // propagate on a one. Resolve the chain with a single binary add.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      gen[i]  = (digits[i] == 2'd2);
      prop[i] = (digits[i] == 2'd1);
    end
    sum   = (gen | prop) + gen + DIGITS'(bit_in);
    carry = sum ^ (gen | prop) ^ gen;
    for (int i = 0; i < DIGITS; i++) begin
      unique case (digits[i])
        2'd0:    digits_dbl[i] = {1'b0, carry[i]};
        2'd1:    digits_dbl[i] = carry[i] ? 2'd0 : 2'd2;
        2'd2:    digits_dbl[i] = carry[i] ? 2'd2 : 2'd1;
        default: digits_dbl[i] = 2'd0;
      endcase
      occ_dbl[i] = occ[i] | (digits_dbl[i] != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      digits <= '0;
      occ    <= DIGITS'(1);
    end else if (ctrl.step) begin
      digits <= digits_dbl;
      occ    <= occ_dbl;
    end else if (ctrl.shift) begin
      digits <= digits << 2;
      occ    <= occ << 1;
    end
  end

  assign top_digit = digits[DIGITS-1];
  assign top_sig   = occ[DIGITS-1];

endmodule

### tb/sv/signed_binary_to_ternary_ascii_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for signed_binary_to_ternary_ascii: directed and random
// values, a base-3 character scoreboard, bursty sender and stalling receiver.
// Depends on sbta_pkg and the converter RTL.
module signed_binary_to_ternary_ascii_tb;

  localparam int VALUE_WIDTH   = 64;
  localparam int RANDOM_VALUES = 100;
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off, once per run
  localparam int DRAIN_CYCLES  = 150;  // wait after the drain, to catch stray characters

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } ternary_char_t;

  // Predict the character run of each accepted value and check the
  // characters that come out against it, oldest first.
  class ternary_scoreboard;
    ternary_char_t expected_chars[$];
    int            errors;
    int            width;

    function new(int w);
      width  = w;
      errors = 0;
    endfunction

    function void note_value(logic [63:0] v);
      logic [63:0]      mask;
      logic [63:0]      sign_bit;
      logic [63:0]      bits;
      logic [63:0]      mag;
      logic             neg;
      sbta_pkg::digit_t digits[$];
      mask     = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
      sign_bit = 64'd1 << (width - 1);
      bits     = v & mask;
      neg      = (bits & sign_bit) != 0;
      mag      = neg ? ((~bits + 64'd1) & mask) : bits;
      if (mag == 0) begin
        expected_chars.push_back('{sbta_pkg::CH_ZERO, 1'b1});
        return;
      end
      while (mag != 0) begin
        digits.push_front(2'(mag % 64'd3));
        mag = mag / 64'd3;
      end
      if (neg)
        expected_chars.push_back('{sbta_pkg::CH_MINUS, 1'b0});
      foreach (digits[i])
        expected_chars.push_back('{6'(sbta_pkg::CH_ZERO + digits[i]),
                                   i == digits.size() - 1});
    endfunction

    function void check_char(logic [5:0] code, logic last);
      ternary_char_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected character %0d last %0b", code, last);
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: character %0d last %0b, expected %0d last %0b",
                   code, last, want.code, want.last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic [63:0] value;
  logic        value_valid;
  logic        value_stall;
  logic [5:0]  character;
  logic        last;
  logic        character_valid;
  logic        character_stall;

  ternary_scoreboard sb = new(VALUE_WIDTH);
  int values_sent = 0;
  int burst_left  = 0;

  signed_binary_to_ternary_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .value          (value),
    .value_valid    (value_valid),
    .value_stall    (value_stall),
    .character      (character),
    .last           (last),
    .character_valid(character_valid),
    .character_stall(character_stall)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random value: full-width patterns four times in ten, else numbers of random
  // bit length or tiny magnitudes, either sign, so short and long runs mix.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          kind;
    kind = $urandom_range(0, 9);
    v    = {$urandom, $urandom};
    if (kind < 4)
      return v;
    if (kind < 7)
      v = v >> $urandom_range(1, 63);
    else
      v = 64'($urandom_range(0, 40));
    if ($urandom_range(0, 1))
      v = 64'd0 - v;
    return v;
  endfunction

  // Offer one value and hold it until the transfer; between bursts drop
  // valid for a random gap so idle cycles land on every phase of a number.
  task automatic send_value(logic [63:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 12);
      value_valid <= 1'b0;
      value       <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
    end
    value       <= v;
    value_valid <= 1'b1;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    sb.note_value(v);
    values_sent++;
    burst_left--;
  endtask

  // Receiver: check each character transfer, then pick the stall for the
  // next cycle. Stall patterns change in segments of random length; once
  // enough values have gone in, hold off for a long stretch so the block
  // backs up and stalls its input.
  initial begin : receiver
    int seg_left;
    int mode;
    int hold_left;
    bit hold_done;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    hold_done = 0;
    character_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && character_valid && !character_stall)
        sb.check_char(character, last);
      if (!hold_done && values_sent >= 30) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        character_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          0: character_stall <= 1'b0;
          1: character_stall <= ($urandom_range(0, 3) == 0);
          2: character_stall <= ($urandom_range(0, 3) != 0);
          default: character_stall <= ~character_stall;
        endcase
      end
    end
  end

  // Stimulus: directed corners, then random values, then drain and report.
  initial begin : stimulus
    static logic [63:0] directed[$] = '{
      64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 64'hFFFF_FFFF_FFFF_FFFE,
      64'd3, 64'hFFFF_FFFF_FFFF_FFFD, 64'd8, 64'd9, 64'd26, 64'd27,
      64'd4052555153018976267, 64'd4052555153018976266,
      64'd0 - 64'd4052555153018976267, 64'h4000_0000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0
    };
    rst         <= 1'b1;
    value       <= '0;
    value_valid <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_value(directed[i]);
    repeat (RANDOM_VALUES)
      send_value(random_value());
    value_valid <= 1'b0;

    // Drain every expected character, then watch for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("signed_binary_to_ternary_ascii test passed");
    else
      $display("signed_binary_to_ternary_ascii test failed");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("signed_binary_to_ternary_ascii test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/sbta_pkg.sv
rtl/core/sbta_conv.sv
rtl/core/signed_binary_to_ternary_ascii.sv
tb/sv/signed_binary_to_ternary_ascii_tb.sv
